>>> rtl/q2e_pkg.sv
// Shared constants and the arctangent table for the quaternion to Euler angle block.
// Depends on nothing; every other file imports it.
package q2e_pkg;

  localparam int QUAT_FRAC_BITS_DEF  = 30;
  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int QUAT_W  = 32;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;
  localparam int ANG_W   = 32;
  localparam int DEG_W   = 16;
  localparam int ATAN_TABLE_LEN = 24;

  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [ANG_W-1:0] atan_bam(input int idx);
    logic [ANG_W-1:0] v;
    case (idx)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/quaternion_to_euler_angles.sv
// Top level: quaternion to Z-Y-X Euler angles in degrees.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_cordic.
//
// One request per clock: start is taken whenever busy is low, and busy never
// rises, so a new quaternion may enter every cycle. Each request gives one
// result, shown for a single cycle with done high; the receiver cannot
// stall. The path runs through the product, term and square registers, the
// pipelined square root (one cell per root bit, QUAT_FRAC_BITS + 1 cells),
// the fold, the CORDIC chain (one cell per stage, at most ATAN_TABLE_LEN),
// the scaling register and the output register.
// Angles are signed degrees with ANGLE_FRAC_BITS fraction bits; pitch_clamped
// flags a pitch sine term outside [-1, 1]. Both atan2 operands zero give 0.
module quaternion_to_euler_angles #(
  parameter int QUAT_FRAC_BITS  = q2e_pkg::QUAT_FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [q2e_pkg::QUAT_W-1:0]  quat_w,
  input  logic signed [q2e_pkg::QUAT_W-1:0]  quat_x,
  input  logic signed [q2e_pkg::QUAT_W-1:0]  quat_y,
  input  logic signed [q2e_pkg::QUAT_W-1:0]  quat_z,
  output logic                               done,
  output logic signed [q2e_pkg::ROLL_W-1:0]  roll_deg,
  output logic signed [q2e_pkg::PITCH_W-1:0] pitch_deg,
  output logic signed [q2e_pkg::YAW_W-1:0]   yaw_deg,
  output logic                               pitch_clamped
);
  import q2e_pkg::*;

  localparam int Q      = QUAT_FRAC_BITS;
  localparam int PROD_W = 64 - Q;          // floored product of two components
  localparam int TW     = 66 - Q;          // sine/cosine terms
  localparam int SW     = Q + 2;           // clamped pitch sine
  localparam int SQ_W   = 2 * Q + 2;       // square root operand
  localparam int DLY    = Q + 2;           // square register plus root cells
  localparam int LAT    = Q + CORDIC_STAGES + 7;

  localparam logic signed [TW-1:0] ONE = TW'(1) <<< Q;
  localparam logic [SQ_W-1:0]      ONE_SQ = SQ_W'(1) << (2 * Q);

  // never hold off a request: every stage advances each cycle
  assign busy = 1'b0;

  // product stage
  logic signed [63:0] m_wx, m_yz, m_xx, m_yy, m_wy, m_zx, m_wz, m_xy, m_zz;
  logic signed [PROD_W-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  assign m_wx = quat_w * quat_x;
  assign m_yz = quat_y * quat_z;
  assign m_xx = quat_x * quat_x;
  assign m_yy = quat_y * quat_y;
  assign m_wy = quat_w * quat_y;
  assign m_zx = quat_z * quat_x;
  assign m_wz = quat_w * quat_z;
  assign m_xy = quat_x * quat_y;
  assign m_zz = quat_z * quat_z;

  always_ff @(posedge clk) begin
    p_wx <= PROD_W'(m_wx >>> Q);
    p_yz <= PROD_W'(m_yz >>> Q);
    p_xx <= PROD_W'(m_xx >>> Q);
    p_yy <= PROD_W'(m_yy >>> Q);
    p_wy <= PROD_W'(m_wy >>> Q);
    p_zx <= PROD_W'(m_zx >>> Q);
    p_wz <= PROD_W'(m_wz >>> Q);
    p_xy <= PROD_W'(m_xy >>> Q);
    p_zz <= PROD_W'(m_zz >>> Q);
  end

  // term stage: form the five terms, clamp the pitch sine
  logic signed [TW-1:0] t0_next, t1_next, t2_next, t3_next, t4_next;
  logic signed [TW-1:0] t0, t1, t3, t4;
  logic signed [SW-1:0] s2;
  logic                 clamp;

  assign t0_next = (TW'(p_wx) + TW'(p_yz)) <<< 1;
  assign t1_next = ONE - ((TW'(p_xx) + TW'(p_yy)) <<< 1);
  assign t2_next = (TW'(p_wy) - TW'(p_zx)) <<< 1;
  assign t3_next = (TW'(p_wz) + TW'(p_xy)) <<< 1;
  assign t4_next = ONE - ((TW'(p_yy) + TW'(p_zz)) <<< 1);

  always_ff @(posedge clk) begin
    t0 <= t0_next;
    t1 <= t1_next;
    t3 <= t3_next;
    t4 <= t4_next;
    if (t2_next > ONE) begin
      s2    <= SW'(ONE);
      clamp <= 1'b1;
    end else if (t2_next < -ONE) begin
      s2    <= SW'(-ONE);
      clamp <= 1'b1;
    end else begin
      s2    <= SW'(t2_next);
      clamp <= 1'b0;
    end
  end

  // square of the sine, then the root chain computes floor(sqrt(1 - s*s))
  logic [SQ_W-1:0] sq;
  logic [SQ_W-1:0] rem  [0:Q+1];
  logic [SQ_W-1:0] root [0:Q+1];

  always_ff @(posedge clk) begin
    sq <= SQ_W'(s2 * s2);
  end

  assign rem[0]  = ONE_SQ - sq;
  assign root[0] = '0;

  for (genvar j = 0; j <= Q; j++) begin : g_sqrt
    q2e_sqrt_cell #(.SQ_W(SQ_W), .K(Q - j)) u_cell (
      .clk(clk), .rem_in(rem[j]), .root_in(root[j]),
      .rem_out(rem[j+1]), .root_out(root[j+1])
    );
  end

  // hold the other terms alongside the root chain
  logic signed [TW-1:0] d_t0 [0:DLY-1];
  logic signed [TW-1:0] d_t1 [0:DLY-1];
  logic signed [TW-1:0] d_t3 [0:DLY-1];
  logic signed [TW-1:0] d_t4 [0:DLY-1];
  logic signed [SW-1:0] d_s2 [0:DLY-1];
  logic                 d_cl [0:DLY-1];

  always_ff @(posedge clk) begin
    d_t0[0] <= t0;
    d_t1[0] <= t1;
    d_t3[0] <= t3;
    d_t4[0] <= t4;
    d_s2[0] <= s2;
    d_cl[0] <= clamp;
    for (int k = 1; k < DLY; k++) begin
      d_t0[k] <= d_t0[k-1];
      d_t1[k] <= d_t1[k-1];
      d_t3[k] <= d_t3[k-1];
      d_t4[k] <= d_t4[k-1];
      d_s2[k] <= d_s2[k-1];
      d_cl[k] <= d_cl[k-1];
    end
  end

  logic signed [TW-1:0] cos_p;
  assign cos_p = TW'(signed'({1'b0, root[Q+1][Q:0]}));

  // three atan2 units in parallel
  logic signed [DEG_W-1:0] roll_a, pitch_a, yaw_a;

  q2e_cordic #(.TW(TW), .STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk(clk), .y_in(d_t0[DLY-1]), .x_in(d_t1[DLY-1]), .deg(roll_a)
  );

  q2e_cordic #(.TW(TW), .STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
    .clk(clk), .y_in(TW'(d_s2[DLY-1])), .x_in(cos_p), .deg(pitch_a)
  );

  q2e_cordic #(.TW(TW), .STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
    .clk(clk), .y_in(d_t3[DLY-1]), .x_in(d_t4[DLY-1]), .deg(yaw_a)
  );

  // carry the clamp flag through the atan2 latency (one before the output register)
  localparam int CL_DLY = ((CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES : ATAN_TABLE_LEN)
                          + 2;
  logic cl_pipe [0:CL_DLY-1];

  always_ff @(posedge clk) begin
    cl_pipe[0] <= d_cl[DLY-1];
    for (int k = 1; k < CL_DLY; k++) begin
      cl_pipe[k] <= cl_pipe[k-1];
    end
  end

  // request valid marker, cleared by reset
  logic [LAT-2:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LAT-3:0], start & ~busy};
      done <= vld[LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    roll_deg      <= roll_a;
    pitch_deg     <= pitch_a[PITCH_W-1:0];
    yaw_deg       <= yaw_a;
    pitch_clamped <= cl_pipe[CL_DLY-1];
  end

endmodule

>>> rtl/q2e_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one root bit per cycle.
// Depends on q2e_pkg (import only for house consistency of constants).
module q2e_sqrt_cell #(
  parameter int SQ_W = 62,
  parameter int K    = 0
) (
  input  logic            clk,
  input  logic [SQ_W-1:0] rem_in,
  input  logic [SQ_W-1:0] root_in,
  output logic [SQ_W-1:0] rem_out,
  output logic [SQ_W-1:0] root_out
);
  import q2e_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

  logic [SQ_W-1:0] trial;

  assign trial = root_in + BIT;

  always_ff @(posedge clk) begin
    if (rem_in >= trial) begin
      rem_out  <= rem_in - trial;
      root_out <= (root_in >> 1) + BIT;
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in >> 1;
    end
  end

endmodule

>>> rtl/q2e_cordic_cell.sv
// One CORDIC vectoring micro-rotation with its fixed shift and table angle.
// Depends on q2e_pkg for the arctangent table.
module q2e_cordic_cell #(
  parameter int CW  = 40,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic [31:0]          z_in,
  input  logic                 zero_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic [31:0]          z_out,
  output logic                 zero_out
);
  import q2e_pkg::*;

  localparam logic [ANG_W-1:0] STEP = atan_bam(IDX);

  logic signed [CW-1:0] xs, ys;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  always_ff @(posedge clk) begin
    zero_out <= zero_in;
    if (!y_in[CW-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + STEP;
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - STEP;
    end
  end

endmodule

>>> rtl/q2e_cordic.sv
// atan2 in degrees: half-plane fold, chain of CORDIC cells, degree scaling.
// Depends on q2e_pkg and q2e_cordic_cell. The fold, every cell and the output are registered.
module q2e_cordic #(
  parameter int TW              = 36,
  parameter int STAGES          = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                        clk,
  input  logic signed [TW-1:0]        y_in,
  input  logic signed [TW-1:0]        x_in,
  output logic signed [q2e_pkg::DEG_W-1:0] deg
);
  import q2e_pkg::*;

  localparam int CW    = TW + 2;
  localparam int N     = (STAGES < ATAN_TABLE_LEN) ? STAGES : ATAN_TABLE_LEN;
  localparam longint SCALE = 360 * (64'sd1 <<< ANGLE_FRAC_BITS);

  logic signed [CW-1:0] xs [0:N];
  logic signed [CW-1:0] ys [0:N];
  logic [ANG_W-1:0]     zs [0:N];
  logic                 zf [0:N];
  logic signed [63:0]   scaled;

  // fold the left half plane over and remember the zero vector
  always_ff @(posedge clk) begin
    zf[0] <= (x_in == '0) && (y_in == '0);
    if (x_in[TW-1]) begin
      xs[0] <= -CW'(x_in);
      ys[0] <= -CW'(y_in);
      zs[0] <= HALF_TURN;
    end else begin
      xs[0] <= CW'(x_in);
      ys[0] <= CW'(y_in);
      zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    q2e_cordic_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk(clk), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]), .zero_in(zf[i]),
      .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1]), .zero_out(zf[i+1])
    );
  end

  assign scaled = 64'(signed'(zf[N] ? '0 : zs[N])) * SCALE + 64'sd2147483648;

  always_ff @(posedge clk) begin
    deg <= scaled[32 +: DEG_W];
  end

endmodule

>>> rtl/q2e_checker.sv
// Port-level checks for the quaternion to Euler angle block, bound to the top level.
// Depends on q2e_pkg and quaternion_to_euler_angles.
module q2e_checker #(
  parameter int QUAT_FRAC_BITS  = q2e_pkg::QUAT_FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic signed [q2e_pkg::PITCH_W-1:0] pitch_deg,
  input logic                               pitch_clamped
);
  import q2e_pkg::*;

  localparam int LAT = QUAT_FRAC_BITS + CORDIC_STAGES + 7;
  localparam int NEAR_90 = 86 <<< ANGLE_FRAC_BITS;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a request");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT (done || $past(rst, LAT - 1)))
    else $error("request lost");

  // only meaningful while +-90 degrees fits the pitch field
  if (ANGLE_FRAC_BITS <= 7) begin : g_clamp
    a_clamp_near_ninety: assert property (@(posedge clk) disable iff (rst)
      done && pitch_clamped |-> (pitch_deg > PITCH_W'(NEAR_90)) ||
                                (pitch_deg < -PITCH_W'(NEAR_90)))
      else $error("clamped pitch not near 90 degrees");
  end

endmodule

bind quaternion_to_euler_angles q2e_checker #(
  .QUAT_FRAC_BITS(QUAT_FRAC_BITS),
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
  .CORDIC_STAGES(CORDIC_STAGES)
) u_q2e_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .pitch_deg(pitch_deg), .pitch_clamped(pitch_clamped)
);
